FILE: rtl/core/lsbse_pkg.sv
// Shared types, codes and channel tables for the LSB pixel hiding block.
package lsbse_pkg;

    localparam int unsigned BYTE_BITS  = 8;
    localparam int unsigned PIXEL_W    = 32;
    localparam int unsigned PAYLOAD_W  = 8;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned MAX_CHANS  = 4;

    // Pixel format codes as written to the format register.
    typedef enum logic [1:0] {
        FMT_GRAY8    = 2'd0,
        FMT_RGB555A1 = 2'd1,
        FMT_RGB24    = 2'd2,
        FMT_ARGB32   = 2'd3
    } pix_fmt_t;

    // Direction codes.
    typedef enum logic {
        DIR_EMBED   = 1'b0,
        DIR_EXTRACT = 1'b1
    } dir_t;

    // Register index, taken from the word address bit.
    localparam logic REG_DIRECTION    = 1'b0;
    localparam logic REG_PIXEL_FORMAT = 1'b1;

    localparam pix_fmt_t FMT_RESET = FMT_RGB24;
    localparam dir_t     DIR_RESET = DIR_EMBED;

    // Input item: pixel in the low bits, payload byte above it.
    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload_byte;
        logic [PIXEL_W-1:0]   pixel_in;
    } in_item_t;

    // Result item data: pixel in the low bits, extracted byte above it.
    typedef struct packed {
        logic [PAYLOAD_W-1:0] byte_out;
        logic [PIXEL_W-1:0]   pixel_out;
    } out_item_t;

    // Number of channels that carry payload bits.
    function automatic logic [2:0] chan_count(pix_fmt_t fmt);
        logic [2:0] n;
        begin
            case (fmt)
                FMT_GRAY8:    n = 3'd1;
                FMT_RGB555A1: n = 3'd3;
                FMT_RGB24:    n = 3'd3;
                FMT_ARGB32:   n = 3'd4;
                default:      n = 3'd1;
            endcase
            return n;
        end
    endfunction

    // Payload bits carried by each channel.
    function automatic logic [1:0] chan_bits(pix_fmt_t fmt);
        begin
            return (fmt == FMT_ARGB32) ? 2'd2 : 2'd1;
        end
    endfunction

    // Bit position of a channel's least significant bit within the pixel.
    function automatic logic [4:0] chan_pos(pix_fmt_t fmt, logic [1:0] chan);
        logic [4:0] p;
        begin
            case (fmt)
                FMT_RGB555A1: begin
                    case (chan)
                        2'd1:    p = 5'd5;
                        2'd2:    p = 5'd10;
                        default: p = 5'd0;
                    endcase
                end
                FMT_RGB24:  p = (chan == 2'd3) ? 5'd0 : {chan, 3'b000};
                FMT_ARGB32: p = {chan, 3'b000};
                default:    p = 5'd0;
            endcase
            return p;
        end
    endfunction

endpackage

FILE: rtl/core/lsb_pixel_stego_embed_extract.sv
// LSB pixel hiding block: embeds payload bytes into, or extracts them from,
// the low bits of the colour channels of a pixel stream.
// Input channel s_*: one pixel and one payload byte per item. The payload
// byte is only used when the bit cursor stands at the start of a byte.
// Result channel m_*: the pixel (modified when embedding, unchanged when
// extracting), the extracted byte and, in m_tuser, a flag that is set when
// this pixel completed a byte.
// The APB port holds the direction (address 0) and the pixel format
// (address 4); the user must write them only while the stream is idle,
// which the block does not enforce. Accepted items pass one input register,
// then the channel logic and the cursor update, then the result register.
// One item is accepted every cycle while the receiver takes results; the
// rate is set by the cursor update, which has to finish before the next
// pixel. When the receiver stalls, the result register holds its item and
// one further item waits in the input register; s_tready falls only once
// both are full. Reset clears both stages, the bit cursor, the held and
// gathered bytes, and sets embed direction with the 24-bit format.
module lsb_pixel_stego_embed_extract (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [lsbse_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lsbse_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lsbse_pkg::CFG_DATA_W-1:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pixel_in [31:0], payload_byte [39:32]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pixel_out [31:0], byte_out [39:32]
    output logic [0:0]  m_tuser    // byte_valid [0]
);

    lsbse_pkg::dir_t     dir_reg;
    lsbse_pkg::pix_fmt_t fmt_reg;

    logic                st_valid_reg;
    lsbse_pkg::in_item_t st_item_reg;
    logic                out_valid_reg;
    lsbse_pkg::out_item_t out_item_reg;
    logic                out_flag_reg;

    logic [2:0] bits_done_reg;
    logic [7:0] held_reg;
    logic [7:0] gath_reg;

    logic       out_load;
    logic       st_fire;
    logic       cfg_wr;

    logic [2:0] bits_done_next;
    logic [7:0] held_next;
    logic [7:0] gath_next;
    logic [31:0] pix_next;
    logic [7:0] byte_next;
    logic       done_next;

    // Handshake: the result register loads when empty or being drained.
    assign out_load = !out_valid_reg || m_tready;
    assign st_fire  = st_valid_reg && out_load;
    assign s_tready = !st_valid_reg || out_load;

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_item_reg;
    assign m_tuser[0] = out_flag_reg;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        if (paddr[2] == lsbse_pkg::REG_PIXEL_FORMAT) begin
            prdata = {30'd0, fmt_reg};
        end else begin
            prdata = {31'd0, dir_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg <= lsbse_pkg::DIR_RESET;
            fmt_reg <= lsbse_pkg::FMT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == lsbse_pkg::REG_PIXEL_FORMAT) begin
                fmt_reg <= lsbse_pkg::pix_fmt_t'(pwdata[1:0]);
            end else begin
                dir_reg <= lsbse_pkg::dir_t'(pwdata[0]);
            end
        end
    end

    // Channel logic: walk the format's channels while the byte has bits left.
    always_comb begin
        logic [3:0] pos;
        logic [1:0] nbits;
        logic [1:0] mask;
        logic [1:0] v;
        logic [4:0] sh;
        logic [2:0] cnt;
        logic [7:0] held;
        logic [7:0] gath;
        logic [31:0] pix;

        pos   = {1'b0, bits_done_reg};
        nbits = lsbse_pkg::chan_bits(fmt_reg);
        mask  = (nbits == 2'd2) ? 2'b11 : 2'b01;
        cnt   = lsbse_pkg::chan_count(fmt_reg);
        held  = (bits_done_reg == 3'd0) ? st_item_reg.payload_byte : held_reg;
        gath  = (bits_done_reg == 3'd0) ? 8'd0 : gath_reg;
        pix   = st_item_reg.pixel_in;
        v     = 2'd0;
        sh    = 5'd0;

        for (int c = 0; c < lsbse_pkg::MAX_CHANS; c++) begin
            if (3'(c) < cnt && pos < 4'(lsbse_pkg::BYTE_BITS)) begin
                sh = lsbse_pkg::chan_pos(fmt_reg, 2'(c));
                if (dir_reg == lsbse_pkg::DIR_EXTRACT) begin
                    v    = 2'(pix >> sh) & mask;
                    gath = gath | 8'({6'd0, v} << pos[2:0]);
                end else begin
                    v   = 2'(held >> pos[2:0]) & mask;
                    pix = (pix & ~(32'(mask) << sh)) | (32'(v) << sh);
                end
                pos = pos + 4'(nbits);
            end
        end

        done_next      = (pos >= 4'(lsbse_pkg::BYTE_BITS));
        bits_done_next = done_next ? 3'd0 : pos[2:0];
        held_next      = held;
        gath_next      = gath;
        pix_next       = pix;
        byte_next      = (done_next && dir_reg == lsbse_pkg::DIR_EXTRACT) ? gath : 8'd0;
    end

    // Input register, cursor state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            bits_done_reg <= 3'd0;
            held_reg      <= 8'd0;
            gath_reg      <= 8'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                st_valid_reg <= 1'b1;
            end else if (st_fire) begin
                st_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= st_valid_reg;
            end
            if (st_fire) begin
                bits_done_reg <= bits_done_next;
                held_reg      <= held_next;
                gath_reg      <= gath_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            st_item_reg <= lsbse_pkg::in_item_t'(s_tdata);
        end
        if (st_fire) begin
            out_item_reg.pixel_out <= pix_next;
            out_item_reg.byte_out  <= byte_next;
            out_flag_reg           <= done_next;
        end
    end

endmodule

FILE: rtl/core/lsbse_port_checker.sv
// Port-level checks for the LSB pixel hiding block.
module lsbse_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser
);

    lsbse_pkg::out_item_t out_item;

    assign out_item = lsbse_pkg::out_item_t'(m_tdata);

    // Nothing is offered in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    // An extracted byte is only reported together with a completed byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_item.byte_out != 8'd0 |-> m_tuser[0])
        else $error("byte_out set without byte_valid");

    // An accepted item leads to a result on offer after the input and result registers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("accepted item did not reach the output");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind lsb_pixel_stego_embed_extract lsbse_port_checker u_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: bench/lsb_pixel_stego_embed_extract_tb.sv
`timescale 1ns / 100ps

module lsb_pixel_stego_embed_extract_tb;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned ITEM_TARGET  = 450;
    localparam logic [2:0]  ADDR_DIR     = {lsbse_pkg::REG_DIRECTION, 2'b00};
    localparam logic [2:0]  ADDR_FMT     = {lsbse_pkg::REG_PIXEL_FORMAT, 2'b00};

    // Receiver behaviour over one stretch of cycles.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_THIRD,
        RX_MOSTLY
    } rx_mode_t;

    // One expected result item.
    typedef struct packed {
        logic [31:0] pix;
        logic [7:0]  byt;
        logic        flag;
    } stego_res_t;

    // One row of the directed table; the expected fields count only when typed is set.
    typedef struct packed {
        lsbse_pkg::pix_fmt_t fmt;
        lsbse_pkg::dir_t     dir;
        logic [31:0] pix;
        logic [7:0]  pay;
        logic        typed;
        logic [31:0] e_pix;
        logic [7:0]  e_byte;
        logic        e_flag;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // pixel_in [31:0], payload_byte [39:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // pixel_out [31:0], byte_out [39:32]
    logic [0:0]  m_tuser;    // byte_valid [0]

    // Typed expectation travelling alongside the item that is on offer.
    logic        row_typed;
    stego_res_t  row_exp;

    // Predictor state: settings and the bit cursor with its bytes.
    lsbse_pkg::dir_t     cur_dir;
    lsbse_pkg::pix_fmt_t cur_fmt;
    logic [2:0]  cur_bits;
    logic [7:0]  held_byte;
    logic [7:0]  gathered;

    stego_res_t  awaited_pixels[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned items_sent;
    int unsigned idle_cycles;
    int unsigned burst_left;
    bit          held_off;
    lsbse_pkg::dir_t     drv_dir;
    lsbse_pkg::pix_fmt_t drv_fmt;

    lsb_pixel_stego_embed_extract dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    // Hide or recover the payload bits of one pixel under the current settings.
    task automatic embed_or_recover(input logic [31:0] pix_i, input logic [7:0] pay,
                                    output stego_res_t res);
        int unsigned nch;
        int unsigned nb;
        int unsigned pos;
        int unsigned sh;
        int unsigned c;
        logic [7:0]  msk;
        logic [7:0]  lane;
        logic [7:0]  part;
        logic [31:0] p;
        p   = pix_i;
        nb  = (cur_fmt == lsbse_pkg::FMT_ARGB32) ? 2 : 1;
        msk = (cur_fmt == lsbse_pkg::FMT_ARGB32) ? 8'h03 : 8'h01;
        case (cur_fmt)
            lsbse_pkg::FMT_GRAY8:  nch = 1;
            lsbse_pkg::FMT_ARGB32: nch = 4;
            default:               nch = 3;
        endcase
        pos = 32'(cur_bits);
        // A new byte starts: take the payload and clear the gathered bits.
        if (pos == 0) begin
            held_byte = pay;
            gathered  = 8'h00;
        end
        for (c = 0; c < nch && pos < lsbse_pkg::BYTE_BITS; c++) begin
            if (cur_fmt == lsbse_pkg::FMT_RGB555A1) begin
                sh = 5 * c;
            end else if (cur_fmt == lsbse_pkg::FMT_GRAY8) begin
                sh = 0;
            end else begin
                sh = 8 * c;
            end
            if (cur_dir == lsbse_pkg::DIR_EXTRACT) begin
                // Bits beyond the end of the byte fall off the top.
                lane     = 8'(p >> sh);
                lane     = lane & msk;
                part     = lane << pos;
                gathered = gathered | part;
            end else begin
                // A missing upper payload bit reads as zero.
                lane = (held_byte >> pos) & msk;
                p    = (p & ~({24'd0, msk} << sh)) | ({24'd0, lane} << sh);
            end
            pos += nb;
        end
        res.pix  = p;
        res.byt  = 8'h00;
        res.flag = 1'b0;
        if (pos >= lsbse_pkg::BYTE_BITS) begin
            res.flag = 1'b1;
            if (cur_dir == lsbse_pkg::DIR_EXTRACT) begin
                res.byt = gathered;
            end
            pos = 0;
        end
        cur_bits = pos[2:0];
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        $display("mismatch on %s: got %h, expected %h at %0t", what, got_v, want_v, $time);
        mismatches++;
    endtask

    // Prediction on accepted input items and register writes, checking of result items.
    always @(posedge aclk) begin
        stego_res_t predicted;
        stego_res_t want;
        lsbse_pkg::out_item_t got;
        if (!aresetn) begin
            cur_dir   = lsbse_pkg::DIR_RESET;
            cur_fmt   = lsbse_pkg::FMT_RESET;
            cur_bits  = 3'd0;
            held_byte = 8'h00;
            gathered  = 8'h00;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == lsbse_pkg::REG_PIXEL_FORMAT) begin
                    cur_fmt = lsbse_pkg::pix_fmt_t'(pwdata[1:0]);
                end else begin
                    cur_dir = lsbse_pkg::dir_t'(pwdata[0]);
                end
            end
            if (s_tvalid && s_tready) begin
                embed_or_recover(s_tdata[31:0], s_tdata[39:32], predicted);
                awaited_pixels.push_back(row_typed ? row_exp : predicted);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                got = m_tdata;
                if (awaited_pixels.size() == 0) begin
                    report_mismatch("unexpected item", got.pixel_out, 32'h0);
                end else begin
                    want = awaited_pixels.pop_front();
                    if (got.pixel_out !== want.pix) begin
                        report_mismatch("pixel_out", got.pixel_out, want.pix);
                    end
                    if (got.byte_out !== want.byt) begin
                        report_mismatch("byte_out", {24'd0, got.byte_out}, {24'd0, want.byt});
                    end
                    if (m_tuser[0] !== want.flag) begin
                        report_mismatch("byte_valid", {31'd0, m_tuser[0]}, {31'd0, want.flag});
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: stretches of differing readiness, and one long hold-off.
    initial begin
        rx_mode_t    mode;
        int unsigned span;
        int unsigned k;
        m_tready <= 1'b0;
        held_off = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(16, 64);
            for (k = 0; k < span; k++) begin
                case (mode)
                    RX_OPEN:  m_tready <= 1'b1;
                    RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
                    RX_THIRD: m_tready <= (k % 3 == 0);
                    default:  m_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge aclk);
            end
            if (!held_off && results_seen >= 150 && s_tvalid) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
        end
    end

    // Offer one item, opening a new burst after a random gap when the last one is used up.
    task automatic offer_pixel(input logic [31:0] pix, input logic [7:0] pay,
                               input logic typed, input stego_res_t want);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid  <= 1'b1;
        s_tdata   <= {pay, pix};
        row_typed <= typed;
        row_exp   <= want;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Let the stream run dry before anything else happens. The first edge lets the
    // predictor record the item accepted last.
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write both registers once the block is idle; unused upper bits carry noise.
    task automatic apply_mode(input lsbse_pkg::dir_t dir, input lsbse_pkg::pix_fmt_t fmt);
        logic [31:0] word;
        drain_stream();
        word    = $urandom();
        word[0] = dir;
        reg_write(ADDR_DIR, word);
        word      = $urandom();
        word[1:0] = fmt;
        reg_write(ADDR_FMT, word);
        drv_dir = dir;
        drv_fmt = fmt;
    endtask

    // Stimulus: the directed table first, then random phases of settings.
    initial begin
        stim_row_t   plan[$];
        stim_row_t   r;
        stego_res_t  want;
        int unsigned n;
        int unsigned i;
        logic [31:0] pix;
        aresetn   <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        row_typed <= 1'b0;
        row_exp   <= '0;
        mismatches   = 0;
        results_seen = 0;
        items_sent   = 0;
        burst_left   = 0;

        // Reset settings hold for the first rows, so they need no write.
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_RGB24, lsbse_pkg::DIR_EMBED,
                                   32'h0, 8'hFF, 1'b1, 32'h00010101, 8'h00, 1'b0});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_RGB24, lsbse_pkg::DIR_EMBED,
                                   32'h0, 8'h00, 1'b1, 32'h00010101, 8'h00, 1'b0});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_RGB24, lsbse_pkg::DIR_EMBED,
                                   32'h0, 8'h00, 1'b1, 32'h00000101, 8'h00, 1'b1});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_GRAY8, lsbse_pkg::DIR_EMBED,
                                   32'h0, 8'hA5, 1'b1, 32'h00000001, 8'h00, 1'b0});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_GRAY8, lsbse_pkg::DIR_EMBED,
                                   32'h12345678, 8'h3C, 1'b0, 32'h0, 8'h00, 1'b0});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_GRAY8, lsbse_pkg::DIR_EMBED,
                                   32'hFFFFFFFF, 8'h00, 1'b0, 32'h0, 8'h00, 1'b0});
        // Two-bit channels reached with one payload bit left.
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_ARGB32, lsbse_pkg::DIR_EMBED,
                                   32'hFFFFFFFF, 8'h00, 1'b0, 32'h0, 8'h00, 1'b0});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_ARGB32, lsbse_pkg::DIR_EMBED,
                                   32'hFFFFFFFF, 8'h00, 1'b1, 32'hFCFCFCFC, 8'h00, 1'b1});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_ARGB32, lsbse_pkg::DIR_EMBED,
                                   32'h0, 8'hFF, 1'b1, 32'h03030303, 8'h00, 1'b1});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_RGB555A1, lsbse_pkg::DIR_EMBED,
                                   32'h0000FFFF, 8'h00, 1'b1, 32'h0000FBDE, 8'h00, 1'b0});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_RGB555A1, lsbse_pkg::DIR_EMBED,
                                   32'hFFFF0000, 8'hC3, 1'b0, 32'h0, 8'h00, 1'b0});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_RGB555A1, lsbse_pkg::DIR_EMBED,
                                   32'h80007FFF, 8'h00, 1'b0, 32'h0, 8'h00, 1'b0});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_ARGB32, lsbse_pkg::DIR_EXTRACT,
                                   32'h03020100, 8'h00, 1'b1, 32'h03020100, 8'hE4, 1'b1});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_ARGB32, lsbse_pkg::DIR_EXTRACT,
                                   32'hFFFFFFFF, 8'h00, 1'b1, 32'hFFFFFFFF, 8'hFF, 1'b1});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_ARGB32, lsbse_pkg::DIR_EXTRACT,
                                   32'h0, 8'hFF, 1'b1, 32'h0, 8'h00, 1'b1});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_RGB24, lsbse_pkg::DIR_EXTRACT,
                                   32'h00010101, 8'h5A, 1'b1, 32'h00010101, 8'h00, 1'b0});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_RGB24, lsbse_pkg::DIR_EXTRACT,
                                   32'hDEADBEEF, 8'h00, 1'b0, 32'h0, 8'h00, 1'b0});
        // Direction flipped in mid-byte: the held payload carries on.
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_RGB24, lsbse_pkg::DIR_EMBED,
                                   32'h00FF00FF, 8'h00, 1'b0, 32'h0, 8'h00, 1'b0});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_GRAY8, lsbse_pkg::DIR_EXTRACT,
                                   32'hFFFFFFFF, 8'h77, 1'b0, 32'h0, 8'h00, 1'b0});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_ARGB32, lsbse_pkg::DIR_EXTRACT,
                                   32'h5A5A5A5A, 8'h00, 1'b0, 32'h0, 8'h00, 1'b0});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_RGB555A1, lsbse_pkg::DIR_EXTRACT,
                                   32'hFFFFFFFF, 8'h00, 1'b0, 32'h0, 8'h00, 1'b0});
        plan.push_back(stim_row_t'{lsbse_pkg::FMT_GRAY8, lsbse_pkg::DIR_EMBED,
                                   32'h0, 8'hFF, 1'b0, 32'h0, 8'h00, 1'b0});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        drv_dir = lsbse_pkg::DIR_RESET;
        drv_fmt = lsbse_pkg::FMT_RESET;

        for (i = 0; i < plan.size(); i++) begin
            r = plan[i];
            if (r.dir != drv_dir || r.fmt != drv_fmt) begin
                apply_mode(r.dir, r.fmt);
            end
            want.pix  = r.e_pix;
            want.byt  = r.e_byte;
            want.flag = r.e_flag;
            offer_pixel(r.pix, r.pay, r.typed, want);
        end

        // Random phases; each one picks new settings, often in mid-byte.
        while (items_sent < ITEM_TARGET) begin
            apply_mode(lsbse_pkg::dir_t'($urandom_range(0, 1)),
                       lsbse_pkg::pix_fmt_t'($urandom_range(0, 3)));
            n = $urandom_range(8, 50);
            for (i = 0; i < n; i++) begin
                case ($urandom_range(0, 7))
                    0:       pix = 32'h0;
                    1:       pix = 32'hFFFFFFFF;
                    default: pix = $urandom();
                endcase
                offer_pixel(pix, 8'($urandom_range(0, 255)), 1'b0, '0);
            end
        end

        drain_stream();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && awaited_pixels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
